FILE: rtl/core/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and constants of the keyed slot table.
// ----------------------------------------------------------------------------
package kst_pkg;

   localparam int SLOTS  = 64;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int KEY_W  = 31;
   localparam int SLOT_W = 6;
   localparam int ACT_W  = 7;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NOTFOUND = 2'd1,
      STAT_NEVER    = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POST
   } state_type;

   typedef struct packed {
      logic             operation;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
      logic              was_present;
      logic [ACT_W-1:0]  active_count;
   } rsp_type;

   // table update decided at the end of a scan, applied when the result leaves
   typedef struct packed {
      logic wr;    // store key, set valid
      logic clr;   // clear valid
      logic grow;  // append a new slot
      logic inc;
      logic dec;
   } commit_type;

endpackage

FILE: rtl/core/kst_key_ram.sv
// ----------------------------------------------------------------------------
// kst_key_ram
// Key store, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kst_key_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [kst_pkg::IDX_W-1:0] wr_addr,
   input  logic [kst_pkg::KEY_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [kst_pkg::IDX_W-1:0] rd_addr,
   output logic [kst_pkg::KEY_W-1:0] rd_data
);
   import kst_pkg::*;

   logic [KEY_W-1:0] mem [SLOTS];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/keyed_slot_table.sv
// ----------------------------------------------------------------------------
// keyed_slot_table: keyed slot allocator with lookup, one request at a time.
// Scan: the key RAM is read one key per cycle over the slots in use (used = slots
//   ever allocated), each compared after its registered read; a hit ends it early.
// A new request is taken only back in idle, once the result is in the output register.
// Reset: synchronous; clears state, counts and all valid bits.
// ----------------------------------------------------------------------------
module keyed_slot_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kst_pkg::rsp_type rsp_data
);
   import kst_pkg::*;

   // sequencer and counters
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] act_ff, act_in;
   logic [SLOTS-1:0] valid_ff, valid_in;

   // scan pipeline: issue index, then compare in the next cycle
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             free_hit_ff, free_hit_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   // request held for the scan
   logic             op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;

   // decided result and table update
   logic [1:0]       res_stat_ff, res_stat_in;
   logic [IDX_W-1:0] res_slot_ff, res_slot_in;
   logic             res_pres_ff, res_pres_in;
   logic [IDX_W-1:0] tgt_ff, tgt_in;
   commit_type       cmt_ff, cmt_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // key RAM hookup
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [KEY_W-1:0] ram_rd_data;

   logic             out_free;
   logic             hit;
   logic             scan_done;
   logic [CNT_W-1:0] act_next;

   kst_key_ram u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tgt_ff),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (iss_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // result register can take a new value this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // read next slot while there are slots in use left to look at
   assign ram_rd_en = (state_ff == ST_SCAN) && (iss_ff < used_ff);
   // a valid slot holding the key; freed slots never match
   assign hit       = rd_pend_ff && valid_ff[rd_idx_ff] && (ram_rd_data == key_ff);
   assign scan_done = !rd_pend_ff && !ram_rd_en;

   assign ram_wr_en = (state_ff == ST_POST) && out_free && cmt_ff.wr;

   always_comb begin
      act_next = act_ff;
      if (cmt_ff.inc) begin
         act_next = act_ff + CNT_W'(1);
      end else if (cmt_ff.dec && (act_ff != '0)) begin
         act_next = act_ff - CNT_W'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      act_in       = act_ff;
      valid_in     = valid_ff;
      iss_in       = iss_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      free_hit_in  = free_hit_ff;
      free_idx_in  = free_idx_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      res_stat_in  = res_stat_ff;
      res_slot_in  = res_slot_ff;
      res_pres_in  = res_pres_ff;
      tgt_in       = tgt_ff;
      cmt_in       = cmt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_data.operation;
               key_in      = req_data.key;
               iss_in      = '0;
               free_hit_in = 1'b0;
               state_in    = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (ram_rd_en) begin
               iss_in     = iss_ff + CNT_W'(1);
               rd_pend_in = 1'b1;
               rd_idx_in  = iss_ff[IDX_W-1:0];
            end
            // later free slots override earlier: highest one wins
            if (rd_pend_ff && !valid_ff[rd_idx_ff]) begin
               free_hit_in = 1'b1;
               free_idx_in = rd_idx_ff;
            end

            res_stat_in = STAT_OK;
            res_slot_in = '0;
            res_pres_in = 1'b0;
            cmt_in      = '0;

            if (hit) begin
               tgt_in   = rd_idx_ff;
               state_in = ST_POST;
               if (op_ff == OP_ADD) begin
                  res_slot_in = rd_idx_ff;
                  res_pres_in = 1'b1;
               end else begin
                  cmt_in.clr = 1'b1;
                  cmt_in.dec = 1'b1;
               end
            end else if (scan_done) begin
               state_in = ST_POST;
               if (op_ff == OP_ADD) begin
                  if (free_hit_ff) begin
                     tgt_in      = free_idx_ff;
                     res_slot_in = free_idx_ff;
                     cmt_in.wr   = 1'b1;
                     cmt_in.inc  = 1'b1;
                  end else if (used_ff == CNT_W'(SLOTS)) begin
                     res_stat_in = STAT_FULL;
                  end else begin
                     tgt_in      = used_ff[IDX_W-1:0];
                     res_slot_in = used_ff[IDX_W-1:0];
                     cmt_in.wr   = 1'b1;
                     cmt_in.grow = 1'b1;
                     cmt_in.inc  = 1'b1;
                  end
               end else if (used_ff == '0) begin
                  res_stat_in = STAT_NEVER;
               end else begin
                  res_stat_in = STAT_NOTFOUND;
               end
            end
         end

         ST_POST: begin
            // table update and result transfer happen together
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = res_stat_ff;
               rsp_in.slot         = SLOT_W'(res_slot_ff);
               rsp_in.was_present  = res_pres_ff;
               rsp_in.active_count = ACT_W'(act_next);
               act_in              = act_next;
               if (cmt_ff.grow) begin
                  used_in = used_ff + CNT_W'(1);
               end
               if (cmt_ff.wr) begin
                  valid_in[tgt_ff] = 1'b1;
               end
               if (cmt_ff.clr) begin
                  valid_in[tgt_ff] = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         act_ff       <= '0;
         valid_ff     <= '0;
         iss_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         free_hit_ff  <= 1'b0;
         cmt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         act_ff       <= act_in;
         valid_ff     <= valid_in;
         iss_ff       <= iss_in;
         rd_pend_ff   <= rd_pend_in;
         free_hit_ff  <= free_hit_in;
         cmt_ff       <= cmt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      free_idx_ff <= free_idx_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      res_stat_ff <= res_stat_in;
      res_slot_ff <= res_slot_in;
      res_pres_ff <= res_pres_in;
      tgt_ff      <= tgt_in;
      rsp_ff      <= rsp_in;
   end

   // active count tracks the valid bits
   a_act_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(act_ff))
      else $error("active count differs from number of valid slots");

   // no slot is valid at or above the allocation mark
   a_valid_below_used: assert property (@(posedge clock) disable iff (reset)
      (valid_ff >> used_ff) == '0)
      else $error("valid slot beyond slots in use");

   a_act_le_used: assert property (@(posedge clock) disable iff (reset)
      act_ff <= used_ff)
      else $error("active count above slots in use");

   // a write targets a slot that is free
   a_write_free_slot: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !valid_ff[tgt_ff])
      else $error("key written over a valid slot");

endmodule
